FILE: design/vtld_pkg.sv
package vtld_pkg;

    localparam int unsigned MaxHeaderBytesDefault = 10;
    localparam int unsigned HeaderCountWidth      = 4;
    localparam int unsigned ShiftWidth            = 6;
    localparam int unsigned GroupBits             = 7;
    localparam int unsigned WordWidth             = 32;

    localparam logic [7:0]            ContBit   = 8'h80;
    localparam logic [ShiftWidth-1:0] ShiftSat  = 6'd63;
    localparam logic [HeaderCountWidth-1:0] HeaderCountSat = 4'd15;

    localparam logic KindHeader = 1'b0;
    localparam logic KindBody   = 1'b1;

    typedef struct packed {
        logic                        in_body;
        logic                        type_complete;
        logic [WordWidth-1:0]        type_accum;
        logic [WordWidth-1:0]        length_accum;
        logic [ShiftWidth-1:0]       bit_shift;
        logic [HeaderCountWidth-1:0] header_count;
        logic [WordWidth-1:0]        body_remaining;
    } t_state;

    typedef struct packed {
        logic                 emit;
        logic                 kind;
        logic [WordWidth-1:0] message_type;
        logic [WordWidth-1:0] body_length;
        logic [7:0]           body_byte;
        logic                 last;
    } t_result;

endpackage

FILE: design/vtld_step.sv
module vtld_step #(
    parameter int unsigned MAX_HEADER_BYTES = vtld_pkg::MaxHeaderBytesDefault
) (
    input  vtld_pkg::t_state  i_state,
    input  logic [7:0]        i_rx_byte,
    output vtld_pkg::t_state  o_state,
    output vtld_pkg::t_result o_result
);
    import vtld_pkg::*;

    localparam logic [HeaderCountWidth-1:0] MaxCount = HeaderCountWidth'(MAX_HEADER_BYTES);

    logic [GroupBits-1:0]  group;
    logic                  ends;
    logic [WordWidth-1:0]  placed;
    logic [ShiftWidth:0]   shift_sum;
    logic [ShiftWidth-1:0] shift_next;
    logic [WordWidth-1:0]  remaining_next;
    logic [WordWidth-1:0]  length_new;

    assign group = i_rx_byte[GroupBits-1:0];
    assign ends  = (i_rx_byte & ContBit) == 8'h00;

    // Groups that would start at bit 32 or beyond add nothing.
    assign placed = i_state.bit_shift[ShiftWidth-1] ? '0
                  : ({{(WordWidth-GroupBits){1'b0}}, group} << i_state.bit_shift[4:0]);

    assign shift_sum  = {1'b0, i_state.bit_shift} + (ShiftWidth+1)'(GroupBits);
    assign shift_next = shift_sum[ShiftWidth] ? ShiftSat : shift_sum[ShiftWidth-1:0];

    assign remaining_next = i_state.body_remaining - WordWidth'(1);
    assign length_new     = i_state.length_accum | placed;

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        o_result.message_type = i_state.type_accum;
        o_result.body_length  = i_state.length_accum;

        if (i_state.in_body) begin
            o_state.body_remaining = remaining_next;
            o_result.emit      = 1'b1;
            o_result.kind      = KindBody;
            o_result.body_byte = i_rx_byte;
            o_result.last      = remaining_next == '0;
            if (remaining_next == '0) begin
                o_state.in_body       = 1'b0;
                o_state.type_complete = 1'b0;
                o_state.type_accum    = '0;
                o_state.length_accum  = '0;
                o_state.bit_shift     = '0;
                o_state.header_count  = '0;
            end
        end else begin
            if (i_state.header_count != HeaderCountSat) begin
                o_state.header_count = i_state.header_count + HeaderCountWidth'(1);
            end

            if (!i_state.type_complete) begin
                o_state.type_accum = i_state.type_accum | placed;
                if (ends) begin
                    o_state.type_complete = 1'b1;
                    o_state.bit_shift     = '0;
                end else begin
                    o_state.bit_shift = shift_next;
                end
            end else begin
                o_state.length_accum = length_new;
                o_state.bit_shift    = shift_next;
            end

            if (i_state.type_complete && ends) begin
                // The length varint ends here, so the header is complete.
                o_result.emit        = 1'b1;
                o_result.kind        = KindHeader;
                o_result.body_length = length_new;
                o_result.last        = length_new == '0;
                if (length_new == '0) begin
                    o_state.type_complete = 1'b0;
                    o_state.type_accum    = '0;
                    o_state.length_accum  = '0;
                    o_state.bit_shift     = '0;
                    o_state.header_count  = '0;
                end else begin
                    o_state.in_body        = 1'b1;
                    o_state.body_remaining = length_new;
                end
            end else if (o_state.header_count >= MaxCount) begin
                // Overlong header: drop it quietly and start again.
                o_state.type_complete = 1'b0;
                o_state.type_accum    = '0;
                o_state.length_accum  = '0;
                o_state.bit_shift     = '0;
                o_state.header_count  = '0;
            end
        end
    end

endmodule

FILE: design/varint_type_length_deframer_core.sv
// Channel   Valid     Stall     Payload
// input     i_valid   o_stall   i_rx_byte
// output    o_valid   i_stall   o_kind, o_message_type, o_body_length, o_body_byte, o_last
//
// One word is taken per cycle while o_stall is low; its result, if any, is decoded from the
// input register, loaded into the result register and then appears on the outputs.
// The latency is set by the input register and the result register around the decode logic.
// Reset is synchronous and active low, and clears the decode state and both valid flags.
// A stall on the output holds the result register and, once the input register is full,
// raises o_stall in the same cycle.
module varint_type_length_deframer_core #(
    parameter int unsigned MAX_HEADER_BYTES = vtld_pkg::MaxHeaderBytesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [31:0] o_message_type,
    output logic [31:0] o_body_length,
    output logic [7:0]  o_body_byte,
    output logic        o_last
);
    import vtld_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    t_result    r_result;
    logic       r_out_valid;
    logic       out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_stall  = r_in_valid && !out_free;

    vtld_step #(
        .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
    ) u_step (
        .i_state  (r_state),
        .i_rx_byte(r_in_byte),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid && n_result.emit;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_result <= n_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_kind         = r_result.kind;
    assign o_message_type = r_result.message_type;
    assign o_body_length  = r_result.body_length;
    assign o_body_byte    = r_result.body_byte;
    assign o_last         = r_result.last;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    import vtld_pkg::*;

    localparam int MaxHdr     = MaxHeaderBytesDefault;
    localparam int CycleLimit = 100000;
    localparam int StreamLen  = 676;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_rx_byte = 8'd0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_kind;
    logic [31:0] o_message_type;
    logic [31:0] o_body_length;
    logic [7:0]  o_body_byte;
    logic        o_last;

    varint_type_length_deframer_core #(
        .MAX_HEADER_BYTES(MaxHdr)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_kind         (o_kind),
        .o_message_type (o_message_type),
        .o_body_length  (o_body_length),
        .o_body_byte    (o_body_byte),
        .o_last         (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Byte stream waiting to be sent, and decoded words still to come out.
    logic [7:0] rx_stream[$];
    t_result    due_words[$];

    int cycle_count    = 0;
    int mismatch_count = 0;
    int bytes_accepted = 0;
    bit word_taken     = 1'b0;
    bit result_taken   = 1'b0;
    bit long_hold      = 1'b0;
    bit quiet_tx       = 1'b0;
    bit quiet_rx       = 1'b0;
    int send_gap       = 0;
    int stall_left     = 0;

    // Deframer state as seen by the prediction.
    bit                          in_body    = 1'b0;
    bit                          type_done  = 1'b0;
    logic [WordWidth-1:0]        type_acc   = '0;
    logic [WordWidth-1:0]        len_acc    = '0;
    logic [ShiftWidth-1:0]       shift_pos  = '0;
    logic [HeaderCountWidth-1:0] hdr_count  = '0;
    logic [WordWidth-1:0]        body_left  = '0;

    function automatic logic [WordWidth-1:0] group_at(logic [6:0] group,
                                                      logic [ShiftWidth-1:0] pos);
        if (pos >= WordWidth) begin
            return '0;
        end
        return {25'd0, group} << pos;
    endfunction

    function automatic logic [ShiftWidth-1:0] shift_after(logic [ShiftWidth-1:0] pos);
        if (int'(pos) + GroupBits > int'(ShiftSat)) begin
            return ShiftSat;
        end
        return pos + ShiftWidth'(GroupBits);
    endfunction

    task automatic restart_header();
        type_done = 1'b0;
        type_acc  = '0;
        len_acc   = '0;
        shift_pos = '0;
        hdr_count = '0;
    endtask

    task automatic deframe_byte(input logic [7:0] rx);
        t_result word;
        bit      ends;
        bit      header_out;
        word       = '0;
        word.emit  = 1'b1;
        ends       = (rx & ContBit) == 8'd0;
        header_out = 1'b0;
        if (in_body) begin
            body_left         = body_left - 1;
            word.kind         = KindBody;
            word.message_type = type_acc;
            word.body_length  = len_acc;
            word.body_byte    = rx;
            word.last         = body_left == 0;
            due_words.push_back(word);
            if (word.last) begin
                in_body = 1'b0;
                restart_header();
            end
        end else begin
            if (hdr_count != HeaderCountSat) begin
                hdr_count = hdr_count + HeaderCountWidth'(1);
            end
            if (!type_done) begin
                type_acc = type_acc | group_at(rx[6:0], shift_pos);
                if (ends) begin
                    type_done = 1'b1;
                    shift_pos = '0;
                end else begin
                    shift_pos = shift_after(shift_pos);
                end
            end else begin
                len_acc = len_acc | group_at(rx[6:0], shift_pos);
                if (ends) begin
                    header_out        = 1'b1;
                    word.kind         = KindHeader;
                    word.message_type = type_acc;
                    word.body_length  = len_acc;
                    word.last         = len_acc == 0;
                    due_words.push_back(word);
                    if (len_acc == 0) begin
                        restart_header();
                    end else begin
                        in_body   = 1'b1;
                        body_left = len_acc;
                    end
                end else begin
                    shift_pos = shift_after(shift_pos);
                end
            end
            // A header that has used up its byte budget is thrown away.
            if (!header_out && hdr_count >= MaxHdr) begin
                restart_header();
            end
        end
    endtask

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("tb_top: mismatch at cycle %0d: %s", cycle_count, what);
        end
    endtask

    // Encodes the low bits of value as a varint of exactly nbytes bytes.
    task automatic add_varint(input logic [63:0] value, input int nbytes);
        logic [7:0] b;
        for (int i = 0; i < nbytes; i++) begin
            b = 8'((value >> (7 * i)) & 64'h7F);
            if (i < nbytes - 1) begin
                b = b | ContBit;
            end
            rx_stream.push_back(b);
        end
    endtask

    task automatic add_frame(input logic [63:0] mtype, input int tbytes,
                             input logic [31:0] blen, input int lbytes);
        add_varint(mtype, tbytes);
        add_varint(64'(blen), lbytes);
        repeat (blen) rx_stream.push_back(8'($urandom));
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Acceptance on both channels is judged here, at the rising edge.
    always @(posedge i_clk) begin
        t_result want;
        word_taken   = i_rst_n && i_valid && !o_stall;
        result_taken = i_rst_n && o_valid && !i_stall;
        if (word_taken) begin
            deframe_byte(i_rx_byte);
            bytes_accepted++;
        end
        if (result_taken) begin
            if (due_words.size() == 0) begin
                flag_mismatch("result word with nothing expected");
            end else begin
                want = due_words.pop_front();
                if (o_kind !== want.kind)
                    flag_mismatch($sformatf("kind got %0d want %0d", o_kind, want.kind));
                if (o_message_type !== want.message_type)
                    flag_mismatch($sformatf("message_type got %h want %h",
                                            o_message_type, want.message_type));
                if (o_body_length !== want.body_length)
                    flag_mismatch($sformatf("body_length got %h want %h",
                                            o_body_length, want.body_length));
                if (o_body_byte !== want.body_byte)
                    flag_mismatch($sformatf("body_byte got %h want %h",
                                            o_body_byte, want.body_byte));
                if (o_last !== want.last)
                    flag_mismatch($sformatf("last got %0d want %0d", o_last, want.last));
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !word_taken) begin
            // The word is stalled and stays as it is.
        end else if (send_gap > 0) begin
            send_gap = send_gap - 1;
            i_valid <= 1'b0;
        end else if (rx_stream.size() != 0) begin
            i_rx_byte <= rx_stream.pop_front();
            i_valid   <= 1'b1;
            if ($urandom_range(0, 39) == 0) begin
                quiet_tx = !quiet_tx;
            end
            send_gap = quiet_tx ? 0 : $urandom_range(0, 3);
        end else begin
            i_valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (result_taken) begin
            if ($urandom_range(0, 39) == 0) begin
                quiet_rx = !quiet_rx;
            end
            stall_left = quiet_rx ? 0 : $urandom_range(0, 3);
        end
        if (long_hold) begin
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Twice in the run the output is held off long enough for the block to back up.
    initial begin
        for (int k = 1; k <= 2; k++) begin
            wait (bytes_accepted >= 220 * k);
            long_hold = 1'b1;
            repeat (80) @(posedge i_clk);
            long_hold = 1'b0;
        end
    end

    initial begin
        int          pick;
        int          tlen;
        int          llen;
        logic [31:0] blen;

        // Empty body, then an all-ones type spread over nine bytes so that the
        // header ends exactly on its last permitted byte.
        add_frame(64'd0, 1, 32'd0, 1);
        add_frame({64{1'b1}}, MaxHdr - 1, 32'd1, 1);
        // Type complete, but the length never ends within the budget.
        add_varint(64'd1, 1);
        repeat (MaxHdr - 1) rx_stream.push_back(ContBit);
        add_frame(64'd3, 1, 32'd1, 1);

        while (rx_stream.size() < StreamLen) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat (MaxHdr) rx_stream.push_back(8'($urandom) | ContBit);
            end else if (pick < 14) begin
                tlen = $urandom_range(1, 4);
                add_varint({$urandom, $urandom}, tlen);
                repeat (MaxHdr - tlen) rx_stream.push_back(8'($urandom) | ContBit);
            end else begin
                pick = $urandom_range(0, 39);
                if (pick < 6) begin
                    blen = 32'd0;
                end else if (pick < 30) begin
                    blen = $urandom_range(1, 8);
                end else if (pick < 39) begin
                    blen = $urandom_range(9, 30);
                end else begin
                    blen = $urandom_range(128, 140);
                end
                if (blen >= 128) begin
                    llen = 2;
                end else begin
                    llen = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 3) : 1;
                end
                if ($urandom_range(0, 3) == 0) begin
                    tlen = $urandom_range(1, MaxHdr - llen);
                end else begin
                    tlen = $urandom_range(1, 3);
                end
                add_frame({$urandom, $urandom} >> $urandom_range(0, 63), tlen, blen, llen);
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_stream.size() != 0 || i_valid) @(posedge i_clk);
        while (due_words.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

FILE: varint_type_length_deframer_core.f
design/vtld_pkg.sv
design/vtld_step.sv
design/varint_type_length_deframer_core.sv
tb/sv/tb_top.sv
